[sv/ddt_pkg.sv]
// Shared types, constants and the unzigzag function for the delta-of-delta time range decoder.
package ddt_pkg;

    localparam int WORD_W  = 64;
    localparam int CNT_OUT_W = 16;

    // Position of the next word inside a block
    localparam logic [1:0] POS_START = 2'd0;
    localparam logic [1:0] POS_DELTA = 2'd1;
    localparam logic [1:0] POS_DOD   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MIN_TIME = 1'b0;
    localparam logic CFG_MAX_TIME = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [1:0] pos;
        logic       halted;
    } ddt_ctrl_t;

    function automatic word_t unzigzag(input word_t y);
        unzigzag = (y >> 1) ^ {WORD_W{y[0]}};
    endfunction

endpackage

[sv/delta_of_delta_time_range_decoder.sv]
// Top level of the delta-of-delta zigzag timestamp range decoder.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one 64-bit code word per item,
//   with first_word marking the start of a new timestamp block. Word 0 is the
//   raw start time, word 1 a zigzag delta, later words zigzag delta-of-deltas.
//   Output channel (out_valid / out_stall) carries exactly one result per item:
//   rebuilt time_value, kept flag, saturating skip/add counts, stopped flag.
//   min_time / max_time are written through cfg_we / cfg_index / cfg_data
//   while the block is idle.
// Timing:
//   Two-stage pipe: input register, then the state update (unzigzag, two
//   chained 64-bit adds, two 64-bit compares) into the result register.
//   An accepted item is held in the input register, then its result is loaded
//   into the result register, which raises out_valid. Throughput is one item
//   per cycle while out_stall is low, set by that single state-update pass.
// Stall:
//   A stalled result holds; the input register still fills, so in_stall only
//   rises when both stages are full and out_stall is high.
// Reset:
//   Pipe empties, block state clears (acts as a block start), min_time = 0,
//   max_time = all ones.
module delta_of_delta_time_range_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  ddt_pkg::word_t               coded_word,
    input  logic                         first_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ddt_pkg::word_t               time_value,
    output logic                         kept,
    output logic [ddt_pkg::CNT_OUT_W-1:0] skipped_count,
    output logic [ddt_pkg::CNT_OUT_W-1:0] added_count,
    output logic                         stopped,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  ddt_pkg::word_t               cfg_data
);
    import ddt_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > CNT_OUT_W) ? COUNT_WIDTH : CNT_OUT_W;

    // config
    word_t min_time_reg;
    word_t max_time_reg;

    // input stage
    logic  s1_valid_reg;
    word_t s1_word_reg;
    logic  s1_first_reg;

    // block state
    ddt_ctrl_t              ctrl_reg,  ctrl_next;
    word_t                  pval_reg,  pval_next;
    word_t                  pdel_reg,  pdel_next;
    logic [COUNT_WIDTH-1:0] skip_reg,  skip_next;
    logic [COUNT_WIDTH-1:0] add_reg,   add_next;

    // result stage
    logic                   out_valid_reg;
    word_t                  value_reg;
    logic                   keep_reg;
    logic [CNT_OUT_W-1:0]   skip_out_reg;
    logic [CNT_OUT_W-1:0]   add_out_reg;
    logic                   stop_reg;

    word_t                  value_c;
    logic                   keep_c;
    logic [EXT_W-1:0]       skip_ext;
    logic [EXT_W-1:0]       add_ext;
    logic [CNT_OUT_W-1:0]   skip_clamp;
    logic [CNT_OUT_W-1:0]   add_clamp;

    logic s2_load;
    logic s1_load;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s2_load;
    assign s1_load  = in_valid && !in_stall;

    ddt_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .ctrl            (ctrl_reg),
        .prev_value      (pval_reg),
        .prev_delta      (pdel_reg),
        .skip_tally      (skip_reg),
        .add_tally       (add_reg),
        .word            (s1_word_reg),
        .first           (s1_first_reg),
        .min_time        (min_time_reg),
        .max_time        (max_time_reg),
        .ctrl_next       (ctrl_next),
        .prev_value_next (pval_next),
        .prev_delta_next (pdel_next),
        .skip_tally_next (skip_next),
        .add_tally_next  (add_next),
        .value           (value_c),
        .keep            (keep_c)
    );

    // counts shown on the port clamp at 16 bits
    assign skip_ext   = EXT_W'(skip_next);
    assign add_ext    = EXT_W'(add_next);
    assign skip_clamp = (skip_ext > EXT_W'({CNT_OUT_W{1'b1}})) ? '1 : skip_ext[CNT_OUT_W-1:0];
    assign add_clamp  = (add_ext > EXT_W'({CNT_OUT_W{1'b1}})) ? '1 : add_ext[CNT_OUT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_time_reg <= '0;
            max_time_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_TIME: min_time_reg <= cfg_data;
                CFG_MAX_TIME: max_time_reg <= cfg_data;
                default:      min_time_reg <= min_time_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg  <= coded_word;
            s1_first_reg <= first_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            pval_reg      <= '0;
            pdel_reg      <= '0;
            skip_reg      <= '0;
            add_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_load)
            begin
                ctrl_reg      <= ctrl_next;
                pval_reg      <= pval_next;
                pdel_reg      <= pdel_next;
                skip_reg      <= skip_next;
                add_reg       <= add_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            value_reg    <= value_c;
            keep_reg     <= keep_c;
            skip_out_reg <= skip_clamp;
            add_out_reg  <= add_clamp;
            stop_reg     <= ctrl_next.halted;
        end
    end

    assign out_valid     = out_valid_reg;
    assign time_value    = value_reg;
    assign kept          = keep_reg;
    assign skipped_count = skip_out_reg;
    assign added_count   = add_out_reg;
    assign stopped       = stop_reg;

    // a kept value never comes with the stop flag
    a_keep_not_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(kept && stopped))
        else $error("kept and stopped both set");

    // a kept value lies inside the configured range
    a_keep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kept) |-> (time_value >= min_time_reg && time_value <= max_time_reg))
        else $error("kept value outside range");

    // input stalls only when the input stage holds an item that cannot move
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in pipe");

endmodule

[sv/ddt_step.sv]
// Combinational update of the block state for one code word.
module ddt_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  ddt_pkg::ddt_ctrl_t         ctrl,
    input  ddt_pkg::word_t             prev_value,
    input  ddt_pkg::word_t             prev_delta,
    input  logic [COUNT_WIDTH-1:0]     skip_tally,
    input  logic [COUNT_WIDTH-1:0]     add_tally,
    input  ddt_pkg::word_t             word,
    input  logic                       first,
    input  ddt_pkg::word_t             min_time,
    input  ddt_pkg::word_t             max_time,
    output ddt_pkg::ddt_ctrl_t         ctrl_next,
    output ddt_pkg::word_t             prev_value_next,
    output ddt_pkg::word_t             prev_delta_next,
    output logic [COUNT_WIDTH-1:0]     skip_tally_next,
    output logic [COUNT_WIDTH-1:0]     add_tally_next,
    output ddt_pkg::word_t             value,
    output logic                       keep
);
    import ddt_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = '1;

    ddt_ctrl_t                c;
    word_t                    pv;
    word_t                    pd;
    logic [COUNT_WIDTH-1:0]   st;
    logic [COUNT_WIDTH-1:0]   at;
    word_t                    dz;

    always_comb
    begin
        // first_word clears block state before the word is used
        c  = first ? '0 : ctrl;
        pv = first ? '0 : prev_value;
        pd = first ? '0 : prev_delta;
        st = first ? '0 : skip_tally;
        at = first ? '0 : add_tally;
        dz = unzigzag(word);

        ctrl_next       = c;
        prev_value_next = pv;
        prev_delta_next = pd;
        skip_tally_next = st;
        add_tally_next  = at;
        value           = '0;
        keep            = 1'b0;

        if (!c.halted)
        begin
            case (c.pos)
                POS_START:
                begin
                    value         = word;
                    ctrl_next.pos = POS_DELTA;
                end
                POS_DELTA:
                begin
                    prev_delta_next = dz;
                    value           = pv + dz;
                    ctrl_next.pos   = POS_DOD;
                end
                default:
                begin
                    prev_delta_next = pd + dz;
                    value           = pv + prev_delta_next;
                end
            endcase
            prev_value_next = value;

            if (value < min_time)
            begin
                if (st != TALLY_MAX)
                    skip_tally_next = st + 1'b1;
            end
            else if (value <= max_time)
            begin
                keep = 1'b1;
                if (at != TALLY_MAX)
                    add_tally_next = at + 1'b1;
            end
            else
            begin
                ctrl_next.halted = 1'b1;
            end
        end
    end

endmodule
